### src/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Types and constants shared by the ARP responder, its cells and interfaces.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int CACHE_ENTRIES   = 64;
    localparam int PENDING_ENTRIES = 8;
    localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIDX_W = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    localparam logic [1:0]  ACT_PACKET  = 2'd0;
    localparam logic [1:0]  ACT_QUERY   = 2'd1;
    localparam logic [1:0]  ACT_ABANDON = 2'd2;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;
    localparam logic [7:0]  HW_SIZE     = 8'd6;
    localparam logic [7:0]  PROTO_SIZE  = 8'd4;
    localparam logic [47:0] MAC_BCAST   = 48'hffff_ffff_ffff;

    localparam logic [1:0]  REG_OWN_IP  = 2'd0;
    localparam logic [1:0]  REG_OWN_MAC = 2'd1;
    localparam logic [1:0]  REG_LINK_UP = 2'd2;

    typedef enum logic [3:0] {
        ST_HIT          = 4'd0,
        ST_MISS         = 4'd1,
        ST_SEND_REQUEST = 4'd2,
        ST_SEND_REPLY   = 4'd3,
        ST_GLEANED      = 4'd4,
        ST_REPLY_LEARNT = 4'd5,
        ST_PEND_RESOLVE = 4'd6,
        ST_FILTERED     = 4'd7,
        ST_MALFORMED    = 4'd8,
        ST_BAD_OPCODE   = 4'd9,
        ST_IPV6         = 4'd10,
        ST_LINK_DOWN    = 4'd11,
        ST_NO_OWN_IP    = 4'd12,
        ST_PEND_FULL    = 4'd13,
        ST_ABANDONED    = 4'd14
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        filter_pass;
        logic [7:0]  hw_addr_size;
        logic [7:0]  proto_addr_size;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic        resolve;
        logic        query_is_ipv6;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic        cache_insert_dropped;
    } result_t;

    // search word travelling down the cache cells
    typedef struct packed {
        logic              valid;
        logic [31:0]       ip;
        logic              hit;
        logic [47:0]       mac;
        logic              free;
        logic [CIDX_W-1:0] fidx;
    } cprobe_t;

    typedef struct packed {
        logic              en;
        logic [CIDX_W-1:0] idx;
        logic [31:0]       ip;
        logic [47:0]       mac;
    } cwrite_t;

    typedef struct packed {
        logic              valid;
        logic [31:0]       ip;
        logic              hit;
        logic [PIDX_W-1:0] hidx;
        logic              free;
        logic [PIDX_W-1:0] fidx;
    } pprobe_t;

    typedef struct packed {
        logic              set_en;
        logic              clr_en;
        logic [PIDX_W-1:0] idx;
        logic [31:0]       ip;
    } pop_t;

endpackage

### src/arp_in_if.sv
// ----------------------------------------------------------------------------
// arp_in_if
// Input channel: one ARP item per word.
// ----------------------------------------------------------------------------
interface arp_in_if import arp_pkg::*;;
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/arp_out_if.sv
// ----------------------------------------------------------------------------
// arp_out_if
// Output channel: one result per word.
// ----------------------------------------------------------------------------
interface arp_out_if import arp_pkg::*;;
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/arp_cache_cell.sv
// ----------------------------------------------------------------------------
// arp_cache_cell
// One cache entry; compares the passing search word and hands it on.
// ----------------------------------------------------------------------------
module arp_cache_cell import arp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CIDX_W-1:0] idx,
    input  cprobe_t           probe_in,
    output cprobe_t           probe_out,
    input  cwrite_t           wr
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    cprobe_t     probe_reg;
    cprobe_t     probe_next;
    logic        match;

    assign match = valid_reg && (ip_reg == probe_in.ip);

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.hit && match)
        begin
            probe_next.hit = 1'b1;
            probe_next.mac = mac_reg;
        end
        if (!probe_in.free && !valid_reg)
        begin
            probe_next.free = 1'b1;
            probe_next.fidx = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (wr.en && wr.idx == idx)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == idx)
        begin
            ip_reg  <= wr.ip;
            mac_reg <= wr.mac;
        end
    end

    assign probe_out = probe_reg;

endmodule

### src/arp_pend_cell.sv
// ----------------------------------------------------------------------------
// arp_pend_cell
// One pending-query entry; compares the passing search word and hands it on.
// ----------------------------------------------------------------------------
module arp_pend_cell import arp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PIDX_W-1:0] idx,
    input  pprobe_t           probe_in,
    output pprobe_t           probe_out,
    input  pop_t              op
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    pprobe_t     probe_reg;
    pprobe_t     probe_next;
    logic        sel;

    assign sel = (op.idx == idx);

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.hit && valid_reg && ip_reg == probe_in.ip)
        begin
            probe_next.hit  = 1'b1;
            probe_next.hidx = idx;
        end
        if (!probe_in.free && !valid_reg)
        begin
            probe_next.free = 1'b1;
            probe_next.fidx = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (op.set_en && sel)
                valid_reg <= 1'b1;
            else if (op.clr_en && sel)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.set_en && sel)
            ip_reg <= op.ip;
    end

    assign probe_out = probe_reg;

endmodule

### src/arp_responder_with_cache_top.sv
// ----------------------------------------------------------------------------
// arp_responder_with_cache_top
// ARP responder with address cache and pending-query table.
// ----------------------------------------------------------------------------
// One word is handled at a time: the search word steps through the row of
// cache cells one cell per cycle, while the shorter pending row is walked in
// parallel; the DECIDE state then writes back and loads the output register
// once that register is free. The result register lets the next word be
// accepted while a result still waits. Registers: own_ip at 0x00, own_mac at
// 0x08, link_up at 0x10.
module arp_responder_with_cache_top import arp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    arp_in_if.sink      in,
    arp_out_if.source   out
);

    typedef enum logic [1:0] {IDLE, SEARCH, DECIDE} state_t;

    state_t      state_reg;
    item_t       item_reg;
    logic        go_reg;
    logic        cdone_reg;
    logic        pdone_reg;
    cprobe_t     cres_reg;
    pprobe_t     pres_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic        link_up_reg;

    cprobe_t     cchain [CACHE_ENTRIES+1];
    pprobe_t     pchain [PENDING_ENTRIES+1];
    cwrite_t     cwr;
    pop_t        pop;
    result_t     res;
    logic [31:0] key;
    logic        can_load;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            REG_LINK_UP: prdata = {63'd0, link_up_reg};
            default:     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
            link_up_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
        begin
            unique case (paddr[4:3])
                REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                REG_LINK_UP: link_up_reg <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // cell rows
    assign key = (item_reg.action == ACT_PACKET) ? item_reg.sender_ip : item_reg.target_ip;

    always_comb
    begin
        cchain[0]       = '0;
        cchain[0].valid = go_reg;
        cchain[0].ip    = key;
        pchain[0]       = '0;
        pchain[0].valid = go_reg;
        pchain[0].ip    = key;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_ENTRIES; gi++)
        begin : g_cache
            arp_cache_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (CIDX_W'(gi)),
                .probe_in  (cchain[gi]),
                .probe_out (cchain[gi+1]),
                .wr        (cwr)
            );
        end
        for (gi = 0; gi < PENDING_ENTRIES; gi++)
        begin : g_pend
            arp_pend_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (PIDX_W'(gi)),
                .probe_in  (pchain[gi]),
                .probe_out (pchain[gi+1]),
                .op        (pop)
            );
        end
    endgenerate

    // decision
    assign can_load = !out_valid_reg || out.ready;

    always_comb
    begin
        res      = '0;
        res.status = ST_ABANDONED;
        cwr      = '0;
        cwr.idx  = cres_reg.fidx;
        cwr.ip   = item_reg.sender_ip;
        cwr.mac  = item_reg.sender_mac;
        pop      = '0;
        pop.idx  = pres_reg.hidx;
        pop.ip   = item_reg.target_ip;
        case (item_reg.action)
            ACT_PACKET:
            begin
                if (!item_reg.filter_pass)
                    res.status = ST_FILTERED;
                else if (item_reg.hw_addr_size != HW_SIZE ||
                         item_reg.proto_addr_size != PROTO_SIZE)
                    res.status = ST_MALFORMED;
                else if (item_reg.arp_opcode == OP_REQUEST ||
                         item_reg.arp_opcode == OP_REPLY)
                begin
                    cwr.en = !cres_reg.hit && cres_reg.free;
                    res.cache_insert_dropped = !cres_reg.hit && !cres_reg.free;
                    if (item_reg.arp_opcode == OP_REQUEST)
                    begin
                        if (item_reg.target_ip == own_ip_reg)
                        begin
                            res.status   = ST_SEND_REPLY;
                            res.peer_mac = item_reg.sender_mac;
                            res.peer_ip  = item_reg.sender_ip;
                        end
                        else
                            res.status = ST_GLEANED;
                    end
                    else if (pres_reg.hit)
                    begin
                        pop.clr_en   = 1'b1;
                        res.status   = ST_PEND_RESOLVE;
                        res.peer_mac = item_reg.sender_mac;
                        res.peer_ip  = item_reg.sender_ip;
                    end
                    else
                        res.status = ST_REPLY_LEARNT;
                end
                else
                    res.status = ST_BAD_OPCODE;
            end
            ACT_QUERY:
            begin
                if (item_reg.query_is_ipv6)
                    res.status = ST_IPV6;
                else if (!link_up_reg)
                    res.status = ST_LINK_DOWN;
                else if (cres_reg.hit)
                begin
                    res.status   = ST_HIT;
                    res.peer_mac = cres_reg.mac;
                    res.peer_ip  = item_reg.target_ip;
                end
                else if (!item_reg.resolve)
                    res.status = ST_MISS;
                else if (own_ip_reg == 32'd0)
                    res.status = ST_NO_OWN_IP;
                else if (pres_reg.free)
                begin
                    pop.set_en   = 1'b1;
                    pop.idx      = pres_reg.fidx;
                    res.status   = ST_SEND_REQUEST;
                    res.peer_mac = MAC_BCAST;
                    res.peer_ip  = item_reg.target_ip;
                end
                else
                    res.status = ST_PEND_FULL;
            end
            default:
                pop.clr_en = pres_reg.hit;
        endcase
        if (state_reg != DECIDE || !can_load)
        begin
            cwr.en     = 1'b0;
            pop.set_en = 1'b0;
            pop.clr_en = 1'b0;
        end
    end

    assign in.ready    = (state_reg == IDLE);
    assign out.valid   = out_valid_reg;
    assign out.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            go_reg        <= 1'b0;
            cdone_reg     <= 1'b0;
            pdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            cres_reg      <= '0;
            pres_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (out_valid_reg && out.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (in.valid && in.payload.action != ACT_UNUSED)
                    begin
                        item_reg  <= in.payload;
                        go_reg    <= 1'b1;
                        cdone_reg <= 1'b0;
                        pdone_reg <= 1'b0;
                        state_reg <= SEARCH;
                    end
                end
                SEARCH:
                begin
                    if (cchain[CACHE_ENTRIES].valid)
                    begin
                        cres_reg  <= cchain[CACHE_ENTRIES];
                        cdone_reg <= 1'b1;
                    end
                    if (pchain[PENDING_ENTRIES].valid)
                    begin
                        pres_reg  <= pchain[PENDING_ENTRIES];
                        pdone_reg <= 1'b1;
                    end
                    if (cdone_reg && pdone_reg)
                        state_reg <= DECIDE;
                end
                DECIDE:
                begin
                    if (can_load)
                    begin
                        out_reg       <= res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARP responder with address cache. Each word
// accepted on the input is run through a local model of the cache, pending
// table and registers. Every result word is compared field by field with
// the oldest prediction. Directed cases come first, then random traffic
// with and without random idling, a long output stall and a full-cache phase.
// ----------------------------------------------------------------------------
module tb_top;
    import arp_pkg::*;

    localparam int LATENCY   = 80;
    localparam int WDOG_MAX  = 5000;
    localparam int HOLD_LONG = 600;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    arp_in_if  in_ch ();
    arp_out_if out_ch ();

    arp_responder_with_cache_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in      (in_ch),
        .out     (out_ch)
    );

    // model state
    logic [31:0] m_own_ip;
    logic [47:0] m_own_mac;
    logic        m_link_up;
    logic        c_valid [CACHE_ENTRIES];
    logic [31:0] c_ip    [CACHE_ENTRIES];
    logic [47:0] c_mac   [CACHE_ENTRIES];
    logic        p_valid [PENDING_ENTRIES];
    logic [31:0] p_ip    [PENDING_ENTRIES];

    result_t     expected_q[$];
    logic [31:0] recent_ips[$];
    logic [31:0] ip_pool[8];

    int  mismatches;
    int  idle_cnt;
    bit  idle_on;
    // number of long output stalls requested so far
    int  rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- model
    function automatic int cache_lookup(logic [31:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (c_valid[i] && c_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // returns 1 when the entry was lost to a full cache
    function automatic logic cache_learn(logic [31:0] ip, logic [47:0] mac);
        if (cache_lookup(ip) >= 0)
            return 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!c_valid[i])
            begin
                c_valid[i] = 1'b1;
                c_ip[i]    = ip;
                c_mac[i]   = mac;
                return 1'b0;
            end
        return 1'b1;
    endfunction

    function automatic bit pending_drop(logic [31:0] ip);
        for (int i = 0; i < PENDING_ENTRIES; i++)
            if (p_valid[i] && p_ip[i] == ip)
            begin
                p_valid[i] = 1'b0;
                return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic bit resolve_word(input item_t it, output result_t r);
        int idx;
        r = '0;
        case (it.action)
            ACT_UNUSED:
                return 1'b0;
            ACT_PACKET:
            begin
                if (!it.filter_pass)
                    r.status = ST_FILTERED;
                else if (it.hw_addr_size != HW_SIZE || it.proto_addr_size != PROTO_SIZE)
                    r.status = ST_MALFORMED;
                else if (it.arp_opcode == OP_REQUEST)
                begin
                    r.cache_insert_dropped = cache_learn(it.sender_ip, it.sender_mac);
                    if (it.target_ip == m_own_ip)
                    begin
                        r.status   = ST_SEND_REPLY;
                        r.peer_mac = it.sender_mac;
                        r.peer_ip  = it.sender_ip;
                    end
                    else
                        r.status = ST_GLEANED;
                end
                else if (it.arp_opcode == OP_REPLY)
                begin
                    r.cache_insert_dropped = cache_learn(it.sender_ip, it.sender_mac);
                    if (pending_drop(it.sender_ip))
                    begin
                        r.status   = ST_PEND_RESOLVE;
                        r.peer_mac = it.sender_mac;
                        r.peer_ip  = it.sender_ip;
                    end
                    else
                        r.status = ST_REPLY_LEARNT;
                end
                else
                    r.status = ST_BAD_OPCODE;
            end
            ACT_QUERY:
            begin
                idx = cache_lookup(it.target_ip);
                if (it.query_is_ipv6)
                    r.status = ST_IPV6;
                else if (!m_link_up)
                    r.status = ST_LINK_DOWN;
                else if (idx >= 0)
                begin
                    r.status   = ST_HIT;
                    r.peer_mac = c_mac[idx];
                    r.peer_ip  = it.target_ip;
                end
                else if (!it.resolve)
                    r.status = ST_MISS;
                else if (m_own_ip == '0)
                    r.status = ST_NO_OWN_IP;
                else
                begin
                    r.status = ST_PEND_FULL;
                    for (int i = 0; i < PENDING_ENTRIES; i++)
                        if (!p_valid[i])
                        begin
                            p_valid[i] = 1'b1;
                            p_ip[i]    = it.target_ip;
                            r.status   = ST_SEND_REQUEST;
                            r.peer_mac = MAC_BCAST;
                            r.peer_ip  = it.target_ip;
                            break;
                        end
                end
            end
            default:
            begin
                void'(pending_drop(it.target_ip));
                r.status = ST_ABANDONED;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------ stimulus
    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic item_t base_word(logic [1:0] act, logic [31:0] tip);
        item_t it;
        it                 = '0;
        it.action          = act;
        it.filter_pass     = 1'b1;
        it.hw_addr_size    = HW_SIZE;
        it.proto_addr_size = PROTO_SIZE;
        it.arp_opcode      = OP_REQUEST;
        it.sender_mac      = rand48();
        it.sender_ip       = $urandom;
        it.target_ip       = tip;
        it.resolve         = 1'b1;
        return it;
    endfunction

    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && recent_ips.size() > 0)
            return recent_ips[$urandom_range(0, recent_ips.size() - 1)];
        else if (r < 75)
            return ip_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic item_t random_word();
        item_t it;
        int    r;
        r  = $urandom_range(0, 99);
        it = base_word(ACT_PACKET, pick_ip());
        if (r < 8)
        begin
            // noise: every field fully random
            it.action          = 2'($urandom);
            it.filter_pass     = 1'($urandom);
            it.hw_addr_size    = 8'($urandom);
            it.proto_addr_size = 8'($urandom);
            it.arp_opcode      = 16'($urandom);
            it.target_ip       = $urandom;
            it.resolve         = 1'($urandom);
            it.query_is_ipv6   = 1'($urandom);
        end
        else if (r < 42)
        begin
            it.arp_opcode  = ($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY;
            it.sender_ip   = pick_ip();
            it.filter_pass = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 1) != 0)
                it.target_ip = m_own_ip;
        end
        else if (r < 82)
        begin
            it.action        = ACT_QUERY;
            it.query_is_ipv6 = ($urandom_range(0, 9) == 0);
            it.resolve       = ($urandom_range(0, 9) < 7);
            recent_ips.push_back(it.target_ip);
            if (recent_ips.size() > 16)
                void'(recent_ips.pop_front());
        end
        else
            it.action = ACT_ABANDON;
        return it;
    endfunction

    task automatic send_word(item_t it);
        int      gap;
        result_t r;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge clk); while (!in_ch.ready);
        if (resolve_word(it, r))
            expected_q.push_back(r);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_OWN_IP:  m_own_ip  = val[31:0];
            REG_OWN_MAC: m_own_mac = val[47:0];
            default:     m_link_up = val[0];
        endcase
    endtask

    // -------------------------------------------------------------- checker
    initial
    begin
        result_t exp_r;
        result_t got;
        int      gap;
        int      holds_taken;
        holds_taken  = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (rx_hold != holds_taken)
            begin
                gap         = HOLD_LONG;
                holds_taken = rx_hold;
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got = out_ch.payload;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.status !== exp_r.status || got.peer_mac !== exp_r.peer_mac
                    || got.peer_ip !== exp_r.peer_ip
                    || got.cache_insert_dropped !== exp_r.cache_insert_dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_rejections();
        item_t it;
        send_word(base_word(ACT_QUERY, 32'h0a00_0001));          // link down
        it = base_word(ACT_QUERY, 32'h0a00_0001);
        it.query_is_ipv6 = 1'b1;
        send_word(it);
        it = base_word(ACT_PACKET, 32'h0);
        it.filter_pass = 1'b0;
        send_word(it);
        it = base_word(ACT_PACKET, 32'h0);
        it.hw_addr_size = 8'h00;
        send_word(it);
        it.hw_addr_size = 8'hff;
        send_word(it);
        it = base_word(ACT_PACKET, 32'h0);
        it.proto_addr_size = 8'hff;
        send_word(it);
        it = base_word(ACT_PACKET, 32'h0);
        it.arp_opcode = 16'h0000;
        send_word(it);
        it.arp_opcode = 16'hffff;
        send_word(it);
        it.arp_opcode = 16'h0003;
        send_word(it);
        send_word(base_word(ACT_UNUSED, 32'h0));
        send_word(base_word(ACT_ABANDON, 32'h1234_5678));         // nothing pending
    endtask

    task automatic test_no_own_ip();
        item_t it;
        reg_write(REG_LINK_UP, 64'h1);
        send_word(base_word(ACT_QUERY, 32'hdead_beef));           // miss, no address
        it = base_word(ACT_PACKET, 32'h0);                       // request to zero
        it.sender_ip  = 32'hffff_ffff;
        it.sender_mac = 48'hffff_ffff_ffff;
        send_word(it);
        it = base_word(ACT_QUERY, 32'hffff_ffff);                 // hit
        send_word(it);
        it.resolve = 1'b0;
        it.target_ip = 32'h0;
        send_word(it);                                           // plain miss
    endtask

    task automatic test_pending_table();
        item_t it;
        reg_write(REG_OWN_IP, 64'hc0a8_0001);
        reg_write(REG_OWN_MAC, 64'h0000_0200_0000_0001);
        for (int i = 0; i <= PENDING_ENTRIES; i++)
            send_word(base_word(ACT_QUERY, 32'h0b00_0000 + (i % 3)));
        it = base_word(ACT_PACKET, 32'h0);
        it.arp_opcode = OP_REPLY;
        it.sender_ip  = 32'h0b00_0001;
        send_word(it);                                           // resolves lowest
        send_word(base_word(ACT_ABANDON, 32'h0b00_0000));
        send_word(base_word(ACT_QUERY, 32'h0b00_0001));           // now a hit
        it = base_word(ACT_PACKET, 32'hc0a8_0001);
        send_word(it);                                           // reply to us
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    task automatic test_output_stall();
        rx_hold++;
        for (int i = 0; i < 12; i++)
            send_word(random_word());
        drain();
    endtask

    task automatic test_full_cache();
        item_t it;
        for (int i = 0; i < CACHE_ENTRIES + 8; i++)
        begin
            it = base_word(ACT_PACKET, $urandom);
            it.sender_ip = 32'h2000_0000 + i;
            send_word(it);
        end
        test_random_traffic(150);
    endtask

    initial
    begin
        idle_on    = 1'b1;
        m_own_ip   = '0;
        m_own_mac  = '0;
        m_link_up  = 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            c_valid[i] = 1'b0;
        for (int i = 0; i < PENDING_ENTRIES; i++)
            p_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            ip_pool[i] = 32'h0a00_0000 + i;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rejections();
        test_no_own_ip();
        test_pending_table();
        test_random_traffic(330);
        idle_on = 1'b0;
        test_random_traffic(60);
        idle_on = 1'b1;
        test_output_stall();
        reg_write(REG_OWN_IP, 64'hffff_ffff);
        reg_write(REG_OWN_MAC, 64'hffff_ffff_ffff);
        test_random_traffic(120);
        reg_write(REG_LINK_UP, 64'h0);
        test_random_traffic(40);
        reg_write(REG_LINK_UP, 64'h1);
        reg_write(REG_OWN_IP, 64'h0a00_0003);
        test_full_cache();
        reg_write(REG_OWN_IP, 64'h0);
        test_random_traffic(40);
        drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### arp_responder_with_cache_top.f
src/arp_pkg.sv
src/arp_in_if.sv
src/arp_out_if.sv
src/arp_cache_cell.sv
src/arp_pend_cell.sv
src/arp_responder_with_cache_top.sv
bench/tb_top.sv
